/* sv/bht_pkg.sv */
// Shared types and constants for the bone hierarchy transform core.
package bht_pkg;

	localparam int BONE_W     = 8;
	localparam int ROW_W      = 2;
	localparam int ELEM_W     = 32;
	localparam int ROWS       = 4;
	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 144;
	localparam int OUT_USED_W = BONE_W + ROW_W + ROWS * ELEM_W;

	localparam logic [ROW_W-1:0] LAST_K = 2'd3;

	localparam logic signed [ELEM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ELEM_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		SRC_ROOT,
		SRC_STORE,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [ROW_W-1:0]  k;
		src_t              src;
		logic              wr;
		logic [BONE_W-1:0] bone;
		logic [ROW_W-1:0]  row;
	} stage_ctl_t;

endpackage

/* sv/bht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bht_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/bht_seq.sv */
// Input sequencer: takes words, sweeps the four parent rows and tracks in-flight bones.
module bht_seq import bht_pkg::*; #(
	parameter int MAX_BONES = 256,
	parameter int IDX_W     = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     tvalid,
	output logic                     tready,
	input  logic                     action,
	input  logic [BONE_W-1:0]        bone,
	input  logic [ROW_W-1:0]         row,
	input  logic                     has_parent,
	input  logic [BONE_W-1:0]        parent,
	input  logic signed [ELEM_W-1:0] elems [ROWS],
	output logic                     root_we,
	output logic [IDX_W+ROW_W-1:0]   rd_addr,
	output logic signed [ELEM_W-1:0] loc_row [ROWS],
	output stage_ctl_t               ctl_s0,
	output stage_ctl_t               ctl_s1,
	output stage_ctl_t               ctl_s2
);

	logic              run_q;
	logic              busy_q;
	logic [ROW_W-1:0]  cnt_q;
	logic [BONE_W-1:0] bone_q;
	logic [BONE_W-1:0] parent_q;
	logic [ROW_W-1:0]  row_q;
	src_t              src_q;
	logic              wr_q;
	logic signed [ELEM_W-1:0] loc_q [ROWS];

	logic               take;
	logic               slot_free;
	logic               hazard;
	logic               bone_ok;
	logic               parent_ok;
	src_t               src_in;
	logic [IDX_W+BONE_W-1:0] parent_ext;

	assign bone_ok   = 32'(bone) < 32'(MAX_BONES);
	assign parent_ok = 32'(parent) < 32'(MAX_BONES);
	assign src_in    = has_parent ? (parent_ok ? SRC_STORE : SRC_ZERO) : SRC_ROOT;

	// hold off a child until its parent's rows have reached the store
	assign hazard = !action && has_parent &&
		((busy_q && wr_q && bone_q == parent) ||
		 (ctl_s1.valid && ctl_s1.wr && ctl_s1.bone == parent) ||
		 (ctl_s2.valid && ctl_s2.wr && ctl_s2.bone == parent));

	assign slot_free = !busy_q || cnt_q == LAST_K;
	assign tready    = run_q && adv && slot_free && !hazard;
	assign take      = tvalid && tready;
	assign root_we   = take && action;

	assign parent_ext = {IDX_W'(0), parent_q};
	assign rd_addr    = {parent_ext[IDX_W-1:0], cnt_q};
	assign loc_row    = loc_q;

	always_comb begin
		ctl_s0.valid = busy_q;
		ctl_s0.first = cnt_q == '0;
		ctl_s0.last  = cnt_q == LAST_K;
		ctl_s0.k     = cnt_q;
		ctl_s0.src   = src_q;
		ctl_s0.wr    = wr_q;
		ctl_s0.bone  = bone_q;
		ctl_s0.row   = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			run_q <= 1'b1;
			if (adv) begin
				if (take && !action) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q && cnt_q == LAST_K) begin
					busy_q <= 1'b0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 2'd1;
				end
				ctl_s1 <= ctl_s0;
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !action) begin
			bone_q   <= bone;
			row_q    <= row;
			parent_q <= parent;
			src_q    <= src_in;
			wr_q     <= bone_ok;
			loc_q    <= elems;
		end
	end

endmodule

/* sv/bht_lane.sv */
// One column lane: operand select, multiply, truncate, accumulate and saturate.
module bht_lane import bht_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     adv,
	input  stage_ctl_t               ctl_s0,
	input  stage_ctl_t               ctl_s1,
	input  stage_ctl_t               ctl_s2,
	input  logic signed [ELEM_W-1:0] loc_row [ROWS],
	input  logic signed [ELEM_W-1:0] root_col [ROWS],
	input  logic signed [ELEM_W-1:0] store_rd,
	output logic signed [ELEM_W-1:0] result
);

	localparam int PROD_W = 2 * ELEM_W;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	localparam int ACC_W  = SH_W + 2;

	logic signed [ELEM_W-1:0] a_s1;
	logic signed [ELEM_W-1:0] root_s1;
	logic signed [ELEM_W-1:0] b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] shifted;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum;
	logic                     sat_hi;
	logic                     sat_lo;

	always_comb begin
		case (ctl_s1.src)
			SRC_ROOT:  b_s1 = root_s1;
			SRC_STORE: b_s1 = store_rd;
			default:   b_s1 = '0;
		endcase
	end

	assign shifted = prod_s2 >>> FRAC_BITS;
	assign term    = {{2{shifted[SH_W-1]}}, shifted[SH_W-1:0]};
	assign sum     = (ctl_s2.first ? ACC_W'(0) : acc_q) + term;

	assign sat_hi = !sum[ACC_W-1] && (|sum[ACC_W-2:ELEM_W-1]);
	assign sat_lo = sum[ACC_W-1] && !(&sum[ACC_W-2:ELEM_W-1]);
	assign result = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : sum[ELEM_W-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= loc_row[ctl_s0.k];
			root_s1 <= root_col[ctl_s0.k];
			prod_s2 <= a_s1 * b_s1;
			if (ctl_s2.valid) begin
				acc_q <= sum;
			end
		end
	end

endmodule

/* sv/bht_merge.sv */
// Merge stage: gathers the lane results into the output register and store write.
module bht_merge import bht_pkg::*; #(
	parameter int IDX_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stage_ctl_t               ctl_s2,
	input  logic signed [ELEM_W-1:0] result [ROWS],
	input  logic                     tready,
	output logic                     tvalid,
	output logic [OUT_DATA_W-1:0]    tdata,
	output logic                     adv,
	output logic                     wr_en,
	output logic [IDX_W+ROW_W-1:0]   wr_addr
);

	logic                     valid_q;
	logic [BONE_W-1:0]        bone_q;
	logic [ROW_W-1:0]         row_q;
	logic signed [ELEM_W-1:0] elem_q [ROWS];
	logic                     done;
	logic [IDX_W+BONE_W-1:0]  bone_ext;

	assign adv      = !valid_q || tready;
	assign done     = ctl_s2.valid && ctl_s2.last;
	assign wr_en    = adv && done && ctl_s2.wr;
	assign bone_ext = {IDX_W'(0), ctl_s2.bone};
	assign wr_addr  = {bone_ext[IDX_W-1:0], ctl_s2.row};

	assign tvalid = valid_q;
	assign tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), elem_q[3], elem_q[2], elem_q[1], elem_q[0],
		row_q, bone_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done) begin
			bone_q <= ctl_s2.bone;
			row_q  <= ctl_s2.row;
			elem_q <= result;
		end
	end

endmodule

/* sv/bone_hierarchy_transform_core.sv */
// An accepted bone word passes through the sequencer registers, stages s1 and s2 and the output register.
// A new bone word is accepted only as the previous one starts its last parent-row read, while the output
// is not stalled, set by the four parent-row reads through the single read port of each column store.
// A root load word does no sweep. A child whose parent is still in the pipe waits until it reaches the store.
// Reset: asynchronous, clears control and sets the root matrix to identity;
// the absolute store is not cleared.
module bone_hierarchy_transform_core import bht_pkg::*; #(
	parameter int MAX_BONES = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// bone_index, row_index, has_parent, parent_index, elem_0, elem_1, elem_2, elem_3
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_bone, out_row, abs_elem_0, abs_elem_1, abs_elem_2, abs_elem_3
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int ADDR_W = IDX_W + ROW_W;
	localparam logic signed [ELEM_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

	logic [BONE_W-1:0]        in_bone;
	logic [ROW_W-1:0]         in_row;
	logic                     in_has_parent;
	logic [BONE_W-1:0]        in_parent;
	logic signed [ELEM_W-1:0] in_elem [ROWS];

	logic                     adv;
	logic                     root_we;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	stage_ctl_t               ctl_s0;
	stage_ctl_t               ctl_s1;
	stage_ctl_t               ctl_s2;
	logic signed [ELEM_W-1:0] loc_row [ROWS];
	logic signed [ELEM_W-1:0] root_q [ROWS][ROWS];
	logic signed [ELEM_W-1:0] root_col [ROWS][ROWS];
	logic [ELEM_W-1:0]        store_rd [ROWS];
	logic signed [ELEM_W-1:0] result [ROWS];

	assign in_bone       = s_axis_tdata[7:0];
	assign in_row        = s_axis_tdata[9:8];
	assign in_has_parent = s_axis_tdata[10];
	assign in_parent     = s_axis_tdata[18:11];
	assign in_elem[0]    = s_axis_tdata[50:19];
	assign in_elem[1]    = s_axis_tdata[82:51];
	assign in_elem[2]    = s_axis_tdata[114:83];
	assign in_elem[3]    = s_axis_tdata[146:115];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < ROWS; c++) begin
					root_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (root_we) begin
			root_q[in_row] <= in_elem;
		end
	end

	always_comb begin
		for (int c = 0; c < ROWS; c++) begin
			for (int k = 0; k < ROWS; k++) begin
				root_col[c][k] = root_q[k][c];
			end
		end
	end

	bht_seq #(
		.MAX_BONES(MAX_BONES),
		.IDX_W    (IDX_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tvalid    (s_axis_tvalid),
		.tready    (s_axis_tready),
		.action    (s_axis_tuser),
		.bone      (in_bone),
		.row       (in_row),
		.has_parent(in_has_parent),
		.parent    (in_parent),
		.elems     (in_elem),
		.root_we   (root_we),
		.rd_addr   (rd_addr),
		.loc_row   (loc_row),
		.ctl_s0    (ctl_s0),
		.ctl_s1    (ctl_s1),
		.ctl_s2    (ctl_s2)
	);

	for (genvar c = 0; c < ROWS; c++) begin : g_lane
		bht_ram #(
			.WIDTH (ELEM_W),
			.ADDR_W(ADDR_W)
		) u_ram (
			.clk    (clk),
			.wr_en  (wr_en),
			.wr_addr(wr_addr),
			.wr_data(result[c]),
			.rd_en  (adv),
			.rd_addr(rd_addr),
			.rd_data(store_rd[c])
		);

		bht_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.ctl_s0  (ctl_s0),
			.ctl_s1  (ctl_s1),
			.ctl_s2  (ctl_s2),
			.loc_row (loc_row),
			.root_col(root_col[c]),
			.store_rd(store_rd[c]),
			.result  (result[c])
		);
	end

	bht_merge #(
		.IDX_W(IDX_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.result (result),
		.tready (m_axis_tready),
		.tvalid (m_axis_tvalid),
		.tdata  (m_axis_tdata),
		.adv    (adv),
		.wr_en  (wr_en),
		.wr_addr(wr_addr)
	);

endmodule

/* sv/bht_checker.sv */
// Port-level checks for the bone hierarchy transform core, bound to the top level.
module bht_checker import bht_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic bone_acc;

	assign bone_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_row_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !$past(bone_acc, 1) && !$past(bone_acc, 2) && !$past(bone_acc, 3))
		else $error("input ready during parent row sweep");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
		else $error("output padding not zero");

endmodule

bind bone_hierarchy_transform_core bht_checker u_bht_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* verif/bht_test_pkg.sv */
// Action codes and word field offsets for the bone hierarchy transform testbench.
`timescale 1ns / 1ps
package bht_test_pkg;
	import bht_pkg::*;

	typedef enum logic {
		ACT_BONE      = 1'b0,
		ACT_ROOT_LOAD = 1'b1
	} action_t;

	localparam int IN_ROW_LSB    = BONE_W;
	localparam int IN_HASP_BIT   = BONE_W + ROW_W;
	localparam int IN_PARENT_LSB = IN_HASP_BIT + 1;
	localparam int IN_ELEM_LSB   = IN_PARENT_LSB + BONE_W;
	localparam int OUT_ROW_LSB   = BONE_W;
	localparam int OUT_ELEM_LSB  = BONE_W + ROW_W;

	typedef logic [ROWS-1:0][ELEM_W-1:0] row_vec_t;

endpackage

/* verif/bone_hierarchy_transform_checker.sv */
// Checker: predicts absolute matrix rows from accepted words and compares the output stream.
`timescale 1ns / 1ps
module bone_hierarchy_transform_checker import bht_pkg::*, bht_test_pkg::*; #(
	parameter int MAX_BONES = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    fails,
	output int                    outstanding
);

	typedef struct packed {
		logic [BONE_W-1:0] bone;
		logic [ROW_W-1:0]  row;
		row_vec_t          elem;
	} abs_row_t;

	row_vec_t root_mat [ROWS];
	row_vec_t abs_mat [MAX_BONES][ROWS];
	abs_row_t expected_rows [$];

	function automatic logic [ELEM_W-1:0] dot_column(row_vec_t local_row, row_vec_t m [ROWS],
			int c);
		longint acc;
		acc = 0;
		for (int k = 0; k < ROWS; k++)
			acc += (longint'($signed(local_row[k])) * longint'($signed(m[k][c]))) >>> FRAC_BITS;
		if (acc > longint'(Q_MAX))
			return Q_MAX;
		if (acc < longint'(Q_MIN))
			return Q_MIN;
		return acc[ELEM_W-1:0];
	endfunction

	task automatic absorb_word(input logic [IN_DATA_W-1:0] d, input logic act);
		logic [BONE_W-1:0] bone;
		logic [BONE_W-1:0] parent;
		logic [ROW_W-1:0]  row;
		logic              has_parent;
		row_vec_t          local_row;
		row_vec_t          parent_mat [ROWS];
		abs_row_t          res;
		bone       = d[BONE_W-1:0];
		row        = d[IN_ROW_LSB +: ROW_W];
		has_parent = d[IN_HASP_BIT];
		parent     = d[IN_PARENT_LSB +: BONE_W];
		local_row  = d[IN_ELEM_LSB +: ROWS * ELEM_W];
		if (act == ACT_ROOT_LOAD) begin
			root_mat[row] = local_row;
		end else begin
			if (!has_parent) begin
				parent_mat = root_mat;
			end else if (parent < MAX_BONES) begin
				parent_mat = abs_mat[parent];
			end else begin
				foreach (parent_mat[r])
					parent_mat[r] = '0;
			end
			res.bone = bone;
			res.row  = row;
			for (int c = 0; c < ROWS; c++)
				res.elem[c] = dot_column(local_row, parent_mat, c);
			if (bone < MAX_BONES)
				abs_mat[bone][row] = res.elem;
			expected_rows.push_back(res);
		end
	endtask

	task automatic check_word(input logic [OUT_DATA_W-1:0] d);
		abs_row_t exp_row;
		row_vec_t got_elem;
		if (expected_rows.size() == 0) begin
			$error("output word with no expected row: %h", d);
			fails++;
		end else begin
			exp_row  = expected_rows.pop_front();
			got_elem = d[OUT_ELEM_LSB +: ROWS * ELEM_W];
			if (d[BONE_W-1:0] !== exp_row.bone) begin
				$error("out_bone: expected %0d, got %0d", exp_row.bone, d[BONE_W-1:0]);
				fails++;
			end
			if (d[OUT_ROW_LSB +: ROW_W] !== exp_row.row) begin
				$error("out_row: expected %0d, got %0d", exp_row.row, d[OUT_ROW_LSB +: ROW_W]);
				fails++;
			end
			for (int c = 0; c < ROWS; c++) begin
				if (got_elem[c] !== exp_row.elem[c]) begin
					$error("abs_elem_%0d: expected %h, got %h", c, exp_row.elem[c], got_elem[c]);
					fails++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				root_mat[r]    = '0;
				root_mat[r][r] = ELEM_W'(1) << FRAC_BITS;
			end
			expected_rows.delete();
			fails       = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_word(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				check_word(m_axis_tdata);
			outstanding = expected_rows.size();
		end
	end

endmodule

/* verif/bone_hierarchy_transform_core_test.sv */
// Testbench top: drives bone and root-load words into the core and gives the verdict.
`timescale 1ns / 1ps
module bone_hierarchy_transform_core_test;
	import bht_pkg::*;
	import bht_test_pkg::*;

	localparam int N_ITEMS        = 1850;
	localparam int QUIET_TAIL     = 150;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int NUM_BONES      = 256;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	int                    fails;
	int                    outstanding;

	int       n_sent = 0;
	bit       quiet = 1'b0;
	bit       held_long = 1'b0;
	bit [3:0] rows_done [NUM_BONES];
	bit       is_ready [NUM_BONES];
	int       ready_bones [$];
	int       last_bone = 0;

	bone_hierarchy_transform_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	bone_hierarchy_transform_checker row_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fails         (fails),
		.outstanding   (outstanding)
	);

	always #5 clk = ~clk;

	function automatic row_vec_t mk_row(logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
			logic [31:0] e3);
		return {e3, e2, e1, e0};
	endfunction

	function automatic row_vec_t unit_row(int r);
		row_vec_t v;
		v    = '0;
		v[r] = 32'h0001_0000;
		return v;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			return $urandom_range(0, 262144) - 131072;
		if (pick < 17)
			return $urandom;
		case ($urandom_range(0, 6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			4: return 32'hFFFF_0000;
			5: return 32'h0000_0001;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic row_vec_t rand_row();
		row_vec_t v;
		for (int k = 0; k < ROWS; k++)
			v[k] = rand_elem();
		return v;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_word(logic [BONE_W-1:0] bone,
			logic [ROW_W-1:0] row, logic has_parent, logic [BONE_W-1:0] parent, row_vec_t e);
		logic [IN_DATA_W-1:0] w;
		w                                 = '0;
		w[BONE_W-1:0]                     = bone;
		w[IN_ROW_LSB +: ROW_W]            = row;
		w[IN_HASP_BIT]                    = has_parent;
		w[IN_PARENT_LSB +: BONE_W]        = parent;
		w[IN_ELEM_LSB +: ROWS * ELEM_W]   = e;
		return w;
	endfunction

	task automatic push_word(input action_t act, input logic [IN_DATA_W-1:0] w);
		if (!quiet && ((n_sent / 160) % 3 != 1) && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= act;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		n_sent++;
		quiet = (n_sent >= N_ITEMS - QUIET_TAIL);
	endtask

	task automatic send_row(input int bone, input int row, input logic has_parent,
			input int parent, input row_vec_t e);
		rows_done[bone][row] = 1'b1;
		if (&rows_done[bone]) begin
			last_bone = bone;
			if (!is_ready[bone]) begin
				is_ready[bone] = 1'b1;
				ready_bones.push_back(bone);
			end
		end
		push_word(ACT_BONE, pack_word(BONE_W'(bone), ROW_W'(row), has_parent,
			BONE_W'(parent), e));
	endtask

	task automatic send_root_row(input int row, input row_vec_t e);
		push_word(ACT_ROOT_LOAD, pack_word(BONE_W'($urandom_range(0, 255)), ROW_W'(row),
			1'($urandom_range(0, 1)), BONE_W'($urandom_range(0, 255)), e));
	endtask

	task automatic pick_parent(output logic has_parent, output int parent);
		if (ready_bones.size() == 0 || $urandom_range(0, 3) == 0) begin
			has_parent = 1'b0;
			parent     = $urandom_range(0, 255);
		end else begin
			has_parent = 1'b1;
			if ($urandom_range(0, 1))
				parent = last_bone;
			else
				parent = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
		end
	endtask

	task automatic send_bone(input int bone);
		logic has_parent;
		int   parent;
		int   r0;
		pick_parent(has_parent, parent);
		r0 = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < ROWS; i++)
			send_row(bone, (r0 + i) % ROWS, has_parent, parent, rand_row());
	endtask

	// watchdog: no word accepted on either side for too long
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : sink
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_long && n_sent >= HOLD_AT) begin
				held_long = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && ((n_sent / 128) % 3 != 2) && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : source
		logic has_parent;
		int   parent;
		int   pick;
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_BONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity root: extremes pass through
		send_row(0, 0, 1'b0, 90, mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1));
		send_row(0, 1, 1'b0, 165, mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0001_0000));
		send_row(0, 2, 1'b0, 0, mk_row(32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000));
		send_row(0, 3, 1'b0, 255, mk_row(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
			32'h7FFF_FFFF));
		// child right behind its parent
		for (int r = 0; r < ROWS; r++)
			send_row(255, r, 1'b1, 0, rand_row());
		send_root_row(0, {ROWS{32'h7FFF_FFFF}});
		send_root_row(1, {ROWS{32'h8000_0000}});
		send_root_row(2, mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000));
		send_root_row(3, rand_row());
		// saturate both ways against the loaded root
		send_row(1, 0, 1'b0, 0, {ROWS{32'h7FFF_FFFF}});
		send_row(1, 1, 1'b0, 0, {ROWS{32'h8000_0000}});
		send_row(1, 2, 1'b0, 0, mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
		send_row(1, 3, 1'b0, 0, mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1));
		for (int r = 0; r < ROWS; r++)
			send_row(2, r, 1'b1, 255, rand_row());
		for (int r = 0; r < ROWS; r++)
			send_root_row(r, unit_row(r));

		while (n_sent < N_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				send_bone($urandom_range(0, 255));
			end else if (pick < 17) begin
				if ($urandom_range(0, 1)) begin
					for (int r = 0; r < ROWS; r++)
						send_root_row(r, ($urandom_range(0, 1)) ? unit_row(r) : rand_row());
				end else begin
					send_root_row($urandom_range(0, 3), rand_row());
				end
			end else begin
				pick_parent(has_parent, parent);
				send_row($urandom_range(0, 255), $urandom_range(0, 3), has_parent, parent,
					rand_row());
			end
		end
		s_axis_tvalid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
